// ===== hw/rtl/threshold_periodic_reporter_unit_macros.svh =====
// Assertion macros for the threshold periodic reporter.
`ifndef THRESHOLD_PERIODIC_REPORTER_UNIT_MACROS_SVH
`define THRESHOLD_PERIODIC_REPORTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define TPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define TPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tpr_pkg.sv =====
// Shared types and constants of the threshold periodic reporter.
`default_nettype none
package tpr_pkg;

  localparam int PERIOD_W      = 32;
  localparam int VALUE_W_DFLT  = 32;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_OUTSIDE     = 3'd1,
    MODE_INSIDE      = 3'd2,
    MODE_AT_OR_BELOW = 3'd3,
    MODE_AT_OR_ABOVE = 3'd4
  } tpr_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 3'd0,
    REG_REQ_CHG  = 3'd1,
    REG_MODE     = 3'd2,
    REG_WIN_LOW  = 3'd3,
    REG_WIN_HIGH = 3'd4
  } tpr_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                require_change;
    tpr_mode_t           mode;
    logic                arm;
  } tpr_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpr_cfg_regs.sv =====
// Configuration register file with report arming.
`default_nettype none
module tpr_cfg_regs
  import tpr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DFLT,
  localparam int CfgW = (VALUE_WIDTH > PERIOD_W) ? VALUE_WIDTH : PERIOD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [CFG_IDX_W-1:0]          wr_index,
  input  logic [CfgW-1:0]               wr_data,
  output tpr_ctl_t                      ctl,
  output logic signed [VALUE_WIDTH-1:0] win_low,
  output logic signed [VALUE_WIDTH-1:0] win_high
);

  logic [PERIOD_W-1:0]           period_r, period_nxt;
  logic                          req_chg_r, req_chg_nxt;
  tpr_mode_t                     mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0]        low_r, low_nxt;
  logic [VALUE_WIDTH-1:0]        high_r, high_nxt;
  logic                          arm_r, arm_nxt;

  always_comb begin
    period_nxt  = period_r;
    req_chg_nxt = req_chg_r;
    mode_nxt    = mode_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    arm_nxt     = 1'b0;
    if (wr_en) begin
      unique case (wr_index)
        REG_PERIOD: begin
          period_nxt = wr_data[PERIOD_W-1:0];
          arm_nxt    = 1'b1;
        end
        REG_REQ_CHG: begin
          req_chg_nxt = wr_data[0];
          arm_nxt     = 1'b1;
        end
        REG_MODE: begin
          // drop codes beyond the last mode, no arming either
          if (wr_data[2:0] <= MODE_AT_OR_ABOVE) begin
            mode_nxt = tpr_mode_t'(wr_data[2:0]);
            arm_nxt  = 1'b1;
          end
        end
        REG_WIN_LOW: begin
          low_nxt = wr_data[VALUE_WIDTH-1:0];
          arm_nxt = 1'b1;
        end
        REG_WIN_HIGH: begin
          high_nxt = wr_data[VALUE_WIDTH-1:0];
          arm_nxt  = 1'b1;
        end
        default: arm_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      req_chg_r <= 1'b0;
      mode_r    <= MODE_OFF;
      low_r     <= '0;
      high_r    <= '0;
      arm_r     <= 1'b0;
    end else begin
      period_r  <= period_nxt;
      req_chg_r <= req_chg_nxt;
      mode_r    <= mode_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      arm_r     <= arm_nxt;
    end
  end

  assign ctl.period         = period_r;
  assign ctl.require_change = req_chg_r;
  assign ctl.mode           = mode_r;
  assign ctl.arm            = arm_r;
  assign win_low            = low_r;
  assign win_high           = high_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpr_eval.sv =====
// Report decision logic and reporter state.
`default_nettype none
module tpr_eval
  import tpr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic signed [VALUE_WIDTH-1:0] sample,
  input  logic                          ms_tick,
  input  logic                          link_ready,
  input  tpr_ctl_t                      ctl,
  input  logic signed [VALUE_WIDTH-1:0] win_low,
  input  logic signed [VALUE_WIDTH-1:0] win_high,
  output logic                          report_sent,
  output logic signed [VALUE_WIDTH-1:0] report_value,
  output logic                          report_held
);

  localparam logic signed [VALUE_WIDTH-1:0] ValMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] ValMin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [PERIOD_W-1:0]           elapsed_r, elapsed_nxt;
  logic signed [VALUE_WIDTH-1:0] last_r, last_nxt;
  logic                          held_r, held_nxt;
  logic signed [VALUE_WIDTH-1:0] held_val_r, held_val_nxt;

  logic [PERIOD_W-1:0] elapsed_inc;
  logic                thr_ok;
  logic                due;
  logic                pending;

  always_comb begin
    // tick counts before the due test, saturate at the top
    elapsed_inc = elapsed_r;
    if (ms_tick && (elapsed_r != '1)) begin
      elapsed_inc = elapsed_r + PERIOD_W'(1);
    end
  end

  always_comb begin
    case (ctl.mode)
      MODE_OUTSIDE:     thr_ok = (sample <= win_low) || (sample >= win_high);
      MODE_INSIDE:      thr_ok = (sample >= win_low) && (sample <= win_high);
      MODE_AT_OR_BELOW: thr_ok = (sample <= win_low) || (sample == ValMax);
      MODE_AT_OR_ABOVE: thr_ok = (sample == ValMin) || (sample >= win_low);
      default:          thr_ok = 1'b1;
    endcase
  end

  always_comb begin
    due = !held_r && (ctl.period != '0) && (elapsed_inc >= ctl.period) && thr_ok &&
          !(ctl.require_change && (sample == last_r));
    pending      = held_r || due;
    report_sent  = pending && link_ready;
    report_held  = pending && !link_ready;
    report_value = held_r ? held_val_r : (due ? sample : '0);
  end

  always_comb begin
    elapsed_nxt  = elapsed_r;
    last_nxt     = last_r;
    held_nxt     = held_r;
    held_val_nxt = held_val_r;
    if (ctl.arm) begin
      elapsed_nxt = ctl.period;
    end else if (adv) begin
      elapsed_nxt = due ? '0 : elapsed_inc;
      held_nxt    = report_held;
      if (due) begin
        last_nxt     = sample;
        held_val_nxt = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      last_r    <= ValMax;
      held_r    <= 1'b0;
    end else begin
      elapsed_r <= elapsed_nxt;
      last_r    <= last_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_val_r <= held_val_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/threshold_periodic_reporter_unit.sv =====
// Threshold periodic reporter: one decision per poll.
//
// Polls enter on the in_ channel (sample, ms_tick, link_ready); each poll
// gives exactly one result on the out_ channel (report_sent, report_value,
// report_held). Registers are written on the cfg_ channel, which is always
// ready; a write to a known register arms an immediate report on the next
// due poll, except a mode write with a code beyond the last mode.
// A poll is caught in an input register, decided by combinational compare
// and counter logic, and its result lands in an output register: out_valid
// rises once the result is written there, which waits while an untaken
// result holds the output register. One poll is taken per cycle when the
// receiver keeps out_ready high. The period counter and the held report
// are updated as the result is written, so the decision of each poll
// sees the state left by the one before.
// When out_ready is low the result holds, the input register still takes
// one more poll, and then in_ready drops until the output drains.
// Reset (synchronous, rst_n low) clears the registers to zero, the period
// count to zero, the held report, and sets the last reported value to the
// largest positive sample.
`default_nettype none
`include "threshold_periodic_reporter_unit_macros.svh"
module threshold_periodic_reporter_unit
  import tpr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_W_DFLT,
  localparam int CfgW = (VALUE_WIDTH > PERIOD_W) ? VALUE_WIDTH : PERIOD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_sample,
  input  logic                          in_ms_tick,
  input  logic                          in_link_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_report_sent,
  output logic signed [VALUE_WIDTH-1:0] out_report_value,
  output logic                          out_report_held,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CfgW-1:0]               cfg_data
);

  tpr_ctl_t                      ctl;
  logic signed [VALUE_WIDTH-1:0] win_low;
  logic signed [VALUE_WIDTH-1:0] win_high;

  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] s1_sample_r;
  logic                          s1_tick_r;
  logic                          s1_link_r;
  logic                          s1_adv;

  logic                          ev_sent;
  logic signed [VALUE_WIDTH-1:0] ev_value;
  logic                          ev_held;

  logic                          out_valid_r, out_valid_nxt;
  logic                          sent_r;
  logic signed [VALUE_WIDTH-1:0] value_r;
  logic                          held_r;

  assign cfg_ready = 1'b1;

  tpr_cfg_regs #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .ctl     (ctl),
    .win_low (win_low),
    .win_high(win_high)
  );

  // advance the polled item when the output slot is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
      s1_tick_r   <= in_ms_tick;
      s1_link_r   <= in_link_ready;
    end
    if (s1_adv) begin
      sent_r  <= ev_sent;
      value_r <= ev_value;
      held_r  <= ev_held;
    end
  end

  tpr_eval #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .sample      (s1_sample_r),
    .ms_tick     (s1_tick_r),
    .link_ready  (s1_link_r),
    .ctl         (ctl),
    .win_low     (win_low),
    .win_high    (win_high),
    .report_sent (ev_sent),
    .report_value(ev_value),
    .report_held (ev_held)
  );

  assign out_valid        = out_valid_r;
  assign out_report_sent  = sent_r;
  assign out_report_value = value_r;
  assign out_report_held  = held_r;

  `TPR_ASSERT_IMPL(a_sent_xor_held, clk, rst_n, out_valid, !(sent_r && held_r), "sent and held")
  `TPR_ASSERT_IMPL(a_idle0, clk, rst_n, out_valid && !sent_r && !held_r, value_r == '0, "value")
  `TPR_ASSERT_NEXT(a_hold, clk, rst_n, !in_ready, s1_valid_r && $stable(s1_sample_r), "lost")
  `TPR_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !s1_valid_r, in_ready, "blocked when empty")

endmodule
`default_nettype wire

// ===== dv/tb_threshold_periodic_reporter_unit.sv =====
// Self-checking testbench for the threshold periodic reporter unit.
module tb_threshold_periodic_reporter_unit;
  import tpr_pkg::*;

  localparam int VW = VALUE_W_DFLT;
  localparam int CFG_W = (VW > PERIOD_W) ? VW : PERIOD_W;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [2:0] MODE_CODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_CODE_BAD_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int NUM_PHASES = 17;
  localparam int POLLS_PER_PHASE = 50;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_SHOWN = 40;

  typedef struct {
    logic                 sent;
    logic signed [VW-1:0] value;
    logic                 held;
  } report_t;

  class report_tracker;
    logic [PERIOD_W-1:0]  period;
    logic                 req_change;
    tpr_mode_t            mode;
    logic signed [VW-1:0] win_low;
    logic signed [VW-1:0] win_high;
    logic [PERIOD_W-1:0]  elapsed_ms;
    logic signed [VW-1:0] last_value;
    logic signed [VW-1:0] held_value;
    logic                 held;
    report_t              pending_reports[$];
    int unsigned          mismatches;

    function new();
      period = '0;
      req_change = 1'b0;
      mode = MODE_OFF;
      win_low = '0;
      win_high = '0;
      elapsed_ms = '0;
      last_value = VAL_MAX;
      held_value = '0;
      held = 1'b0;
      mismatches = 0;
    endfunction

    function bit window_passes(input logic signed [VW-1:0] s);
      case (mode)
        MODE_OUTSIDE:     return !(s > win_low && s < win_high);
        MODE_INSIDE:      return (s >= win_low && s <= win_high);
        MODE_AT_OR_BELOW: return (s <= win_low || s == VAL_MAX);
        MODE_AT_OR_ABOVE: return (s == VAL_MIN || s >= win_low);
        default:          return 1'b1;
      endcase
    endfunction

    function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_PERIOD:   period = data[PERIOD_W-1:0];
        REG_REQ_CHG:  req_change = data[0];
        REG_MODE: begin
          // drop out-of-range modes without arming
          if (data[2:0] > MODE_AT_OR_ABOVE) return;
          mode = tpr_mode_t'(data[2:0]);
        end
        REG_WIN_LOW:  win_low = data[VW-1:0];
        REG_WIN_HIGH: win_high = data[VW-1:0];
        default:      return;
      endcase
      elapsed_ms = period;
    endfunction

    function void note_poll(input logic signed [VW-1:0] s, input logic tick,
                            input logic link);
      report_t r;
      bit      due;
      if (tick && elapsed_ms != '1) elapsed_ms++;
      if (!held) begin
        due = (period != 0) && (elapsed_ms >= period);
        if (due && req_change && s == last_value) due = 1'b0;
        if (due && !window_passes(s)) due = 1'b0;
        if (due) begin
          elapsed_ms = '0;
          last_value = s;
          held_value = s;
          held = 1'b1;
        end
      end
      r.sent = 1'b0;
      r.value = '0;
      if (held) begin
        r.value = held_value;
        if (link) begin
          r.sent = 1'b1;
          held = 1'b0;
        end
      end
      r.held = held;
      pending_reports.push_back(r);
    endfunction

    task flag_mismatch(input string msg);
      if (mismatches < MAX_SHOWN) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_report(input logic sent, input logic signed [VW-1:0] value,
                      input logic held_o);
      report_t want;
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sent=%0b value=%0d held=%0b",
                                sent, value, held_o));
        return;
      end
      want = pending_reports.pop_front();
      if (sent !== want.sent)
        flag_mismatch($sformatf("report_sent got %0b want %0b", sent, want.sent));
      if (value !== want.value)
        flag_mismatch($sformatf("report_value got %0d want %0d", value, want.value));
      if (held_o !== want.held)
        flag_mismatch($sformatf("report_held got %0b want %0b", held_o, want.held));
    endtask

    task flag_leftovers();
      if (pending_reports.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [VW-1:0] in_sample;
  logic                 in_ms_tick;
  logic                 in_link_ready;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_report_sent;
  logic signed [VW-1:0] out_report_value;
  logic                 out_report_held;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  report_tracker sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles;

  threshold_periodic_reporter_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_ms_tick       (in_ms_tick),
    .in_link_ready    (in_link_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_report_sent  (out_report_sent),
    .out_report_value (out_report_value),
    .out_report_held  (out_report_held),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_req - 1;
      hold_req = 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_report(out_report_sent, out_report_value, out_report_held);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_poll(input logic signed [VW-1:0] s, input logic tick,
                           input logic link);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_ms_tick <= tick;
    in_link_ready <= link;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_poll(s, tick, link);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_write(idx, data);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_window(input logic [PERIOD_W-1:0] per, input logic req,
                             input logic [2:0] mode, input logic signed [VW-1:0] lo,
                             input logic signed [VW-1:0] hi);
    write_reg(REG_PERIOD, CFG_W'(per));
    write_reg(REG_REQ_CHG, CFG_W'(req));
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_WIN_LOW, CFG_W'(lo));
    write_reg(REG_WIN_HIGH, CFG_W'(hi));
  endtask

  function automatic logic signed [VW-1:0] pick_bound();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return $urandom;
      default: return int'($urandom_range(64)) - 32;
    endcase
  endfunction

  // Favor values on and around the window edges and repeats of the last report
  function automatic logic signed [VW-1:0] pick_sample(input logic signed [VW-1:0] prev);
    case ($urandom_range(9))
      0:       return sb.win_low;
      1:       return sb.win_low + 1;
      2:       return sb.win_low - 1;
      3:       return sb.win_high;
      4:       return sb.win_high + 1;
      5:       return sb.last_value;
      6:       return prev;
      7:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      8:       return $urandom;
      default: return int'($urandom_range(32)) - 16;
    endcase
  endfunction

  initial begin
    logic [PERIOD_W-1:0]  per;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] smp;
    int                   ready_pct;
    int                   tick_pct;

    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_ms_tick <= 1'b0;
    in_link_ready <= 1'b0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PERIOD;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reporting is off out of reset
    send_poll(VAL_MIN, 1'b1, 1'b1);
    send_poll(VAL_MAX, 1'b0, 1'b0);
    drain();

    // largest period: count saturates, bad mode and spare indexes do nothing
    load_window('1, 1'b0, MODE_OFF, '0, '0);
    write_reg(REG_MODE, CFG_W'(MODE_CODE_BAD_LO));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    cfg_release();
    send_poll(0, 1'b1, 1'b0);
    send_poll(5, 1'b1, 1'b0);
    send_poll(7, 1'b0, 1'b1);
    drain();

    load_window(1, 1'b1, MODE_OUTSIDE, -10, 10);
    cfg_release();
    send_poll(-10, 1'b0, 1'b1);
    send_poll(0, 1'b1, 1'b1);
    send_poll(10, 1'b1, 1'b1);
    send_poll(VAL_MIN, 1'b1, 1'b1);
    send_poll(VAL_MAX, 1'b1, 1'b0);
    send_poll(VAL_MAX, 1'b1, 1'b1);
    drain();

    load_window(1, 1'b0, MODE_INSIDE, -5, 5);
    cfg_release();
    send_poll(-6, 1'b1, 1'b1);
    send_poll(-5, 1'b1, 1'b1);
    send_poll(5, 1'b1, 1'b1);
    send_poll(6, 1'b1, 1'b1);
    drain();

    load_window(1, 1'b0, MODE_AT_OR_BELOW, 100, 0);
    cfg_release();
    send_poll(101, 1'b1, 1'b1);
    send_poll(100, 1'b1, 1'b1);
    send_poll(VAL_MAX, 1'b1, 1'b1);
    drain();

    load_window(1, 1'b0, MODE_AT_OR_ABOVE, -100, 0);
    cfg_release();
    send_poll(-101, 1'b1, 1'b1);
    send_poll(VAL_MIN, 1'b1, 1'b1);
    send_poll(-100, 1'b1, 1'b1);
    drain();

    load_window(1, 1'b1, MODE_OFF, 0, 0);
    cfg_release();
    send_poll(42, 1'b1, 1'b1);
    send_poll(42, 1'b1, 1'b1);
    send_poll(43, 1'b1, 1'b1);
    drain();

    smp = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(9))
        0:       per = '0;
        1:       per = '1;
        2:       per = $urandom;
        default: per = $urandom_range(4, 1);
      endcase
      lo = pick_bound();
      hi = pick_bound();
      if (ph == 0) begin
        lo = VAL_MIN;
        hi = VAL_MAX;
      end else if (ph == 1) begin
        lo = VAL_MAX;
        hi = VAL_MIN;
      end
      load_window(per, 1'($urandom_range(1)),
                  3'($urandom_range(MODE_AT_OR_ABOVE, MODE_OFF)), lo, hi);
      if ($urandom_range(2) == 0) begin
        write_reg(REG_MODE, CFG_W'($urandom_range(MODE_CODE_BAD_HI, MODE_CODE_BAD_LO)));
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  CFG_W'($urandom));
      end
      cfg_release();

      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 47;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      // back up the output while the sender keeps pushing
      if (ph == 2) hold_req = HOLD_OFF_CYCLES;
      case ($urandom_range(2))
        0:       ready_pct = 25;
        1:       ready_pct = 70;
        default: ready_pct = 95;
      endcase
      tick_pct = $urandom_range(1) ? 60 : 95;

      for (int k = 0; k < POLLS_PER_PHASE; k++) begin
        if (k == POLLS_PER_PHASE / 2 && ph % 4 == 1) drain();
        smp = pick_sample(smp);
        send_poll(smp, $urandom_range(99) < tick_pct, $urandom_range(99) < ready_pct);
      end
      drain();
    end

    sb.flag_leftovers();
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
